@@ sv/rrps_pkg.sv @@
// ----------------------------------------------------------------------------
// rrps_pkg
// shared types and constants for the round-robin task scheduler
// ----------------------------------------------------------------------------
package rrps_pkg;

    localparam int DEF_TASK_SLOTS = 8;
    localparam int PID_W          = 16;
    localparam int TERM_W         = 2;
    localparam int REQ_W          = 4;
    localparam int STAT_W         = 3;
    localparam int CFG_W          = 16;
    localparam int ACC_W          = 32;
    localparam int QL_W           = 17;

    localparam logic [CFG_W-1:0] QUANTUM_RESET = 16'd20;
    localparam logic [CFG_W-1:0] TICK_RESET    = 16'd50;

    localparam logic CFG_QUANTUM = 1'b0;
    localparam logic CFG_TICK    = 1'b1;

    localparam logic [2:0] ST_DEAD     = 3'd0;
    localparam logic [2:0] ST_READY    = 3'd1;
    localparam logic [2:0] ST_RUN      = 3'd2;
    localparam logic [2:0] ST_BLK_RD   = 3'd3;
    localparam logic [2:0] ST_BLK_WR   = 3'd4;
    localparam logic [2:0] ST_BLK_WAIT = 3'd5;

    localparam logic [REQ_W-1:0] REQ_RESET  = 4'd0;
    localparam logic [REQ_W-1:0] REQ_TICK   = 4'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 4'd2;
    localparam logic [REQ_W-1:0] REQ_WRITE  = 4'd3;
    localparam logic [REQ_W-1:0] REQ_CREATE = 4'd4;
    localparam logic [REQ_W-1:0] REQ_KILL   = 4'd5;
    localparam logic [REQ_W-1:0] REQ_WAIT   = 4'd6;
    localparam logic [REQ_W-1:0] REQ_CPUERR = 4'd7;
    localparam logic [REQ_W-1:0] REQ_IORDY  = 4'd8;

    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NO_CUR   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NO_SLOT  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FND  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_BAD_WAIT = 3'd4;
    localparam logic [STAT_W-1:0] STAT_BLOCKED  = 3'd5;

    typedef struct packed {
        logic live;
        logic eq;
        logic is_one;
    } t_cmp;

endpackage

@@ sv/rrps_cmp.sv @@
// ----------------------------------------------------------------------------
// rrps_cmp
// shared slot compare unit: liveness, pid match and pid-is-one check for one table slot
// ----------------------------------------------------------------------------
module rrps_cmp (
    input  logic [2:0]                 i_state,
    input  logic [rrps_pkg::PID_W-1:0] i_pid,
    input  logic [rrps_pkg::PID_W-1:0] i_key,
    output rrps_pkg::t_cmp             o_cmp
);
    import rrps_pkg::*;

    always_comb begin
        o_cmp.live   = (i_state != ST_DEAD);
        o_cmp.eq     = (i_pid == i_key);
        o_cmp.is_one = (i_pid == PID_W'(1));
    end

endmodule

@@ sv/round_robin_process_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// round_robin_process_scheduler_top
// task table with round-robin dispatch and time quantum, one event per word
//
//   channel | signals                          | direction
//   in      | i_in_valid / o_in_ready + fields | event word in
//   out     | o_out_valid / i_out_ready + flds | dispatch result word out
//   cfg     | i_cfg_we, i_cfg_idx, i_cfg_wdata | register write
//
// ready stays low while an event runs through the event scan (if any), the wake
// pass and the dispatch search, plus a pass over all slots for each slot blocked
// on wait, all through one compare unit
// the final state is held while the previous result word is not yet taken
// synchronous active-low reset clears the table and returns to idle
// a new word is taken while the previous result still waits at the output
// ----------------------------------------------------------------------------
module round_robin_process_scheduler_top #(
    parameter int TASK_SLOTS = rrps_pkg::DEF_TASK_SLOTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [rrps_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [rrps_pkg::REQ_W-1:0]         i_req_type,
    input  logic [rrps_pkg::PID_W-1:0]         i_target_pid,
    input  logic                               i_device_ready,
    input  logic [rrps_pkg::TERM_W-1:0]        i_ready_terminal,
    input  logic                               i_io_direction,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_running_valid,
    output logic [$clog2(TASK_SLOTS)-1:0]      o_running_slot,
    output logic [rrps_pkg::PID_W-1:0]         o_running_pid,
    output logic [rrps_pkg::TERM_W-1:0]        o_running_terminal,
    output logic [rrps_pkg::STAT_W-1:0]        o_status,
    output logic [rrps_pkg::PID_W-1:0]         o_child_pid,
    output logic                               o_preempted,
    output logic                               o_all_done,
    output logic [rrps_pkg::ACC_W-1:0]         o_idle_time,
    output logic [rrps_pkg::ACC_W-1:0]         o_preempt_total
);
    import rrps_pkg::*;

    localparam int SW = $clog2(TASK_SLOTS);
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam logic [SW-1:0] LAST = SW'(TASK_SLOTS - 1);

    localparam logic [3:0] P_IDLE  = 4'd0;
    localparam logic [3:0] P_EXEC  = 4'd1;
    localparam logic [3:0] P_CLR   = 4'd2;
    localparam logic [3:0] P_SCAN  = 4'd3;
    localparam logic [3:0] P_ACT   = 4'd4;
    localparam logic [3:0] P_WOUT  = 4'd5;
    localparam logic [3:0] P_WIN   = 4'd6;
    localparam logic [3:0] P_SPREP = 4'd7;
    localparam logic [3:0] P_SCHED = 4'd8;
    localparam logic [3:0] P_DONE  = 4'd9;

    logic [2:0]        r_state [TASK_SLOTS];
    logic [PID_W-1:0]  r_pid   [TASK_SLOTS];
    logic [PID_W-1:0]  r_wpid  [TASK_SLOTS];
    logic              r_wall  [TASK_SLOTS];
    logic [TERM_W-1:0] r_bterm [TASK_SLOTS];
    logic [QL_W-1:0]   r_ql    [TASK_SLOTS];

    logic [CFG_W-1:0]  r_qlen, r_tick;
    logic [3:0]        r_ph;
    logic [SW-1:0]     r_ptr, r_j, r_cur, r_last, r_fidx;
    logic [CW-1:0]     r_cnt, r_live;
    logic              r_cur_v, r_last_v, r_has_cur, r_found, r_other1, r_acc;
    logic [PID_W-1:0]  r_next_pid, r_me, r_key, r_tgt;
    logic [REQ_W-1:0]  r_req;
    logic              r_dev, r_dir;
    logic [TERM_W-1:0] r_term;
    logic [STAT_W-1:0] r_status;
    logic [PID_W-1:0]  r_child;
    logic              r_pre;
    logic [ACC_W-1:0]  r_idle, r_pacc;

    logic              r_ov, r_orv, r_opre;
    logic [SW-1:0]     r_oslot;
    logic [PID_W-1:0]  r_opid, r_ochild;
    logic [TERM_W-1:0] r_oterm;
    logic [STAT_W-1:0] r_ostat;
    logic              r_odone;
    logic [ACC_W-1:0]  r_idle_q, r_pacc_q;

    logic [SW-1:0]     w_ci, w_ptr_nxt, w_start;
    logic [PID_W-1:0]  w_ckey, w_tkill, w_pnext, w_cpid;
    t_cmp              w_cmp;
    logic              w_hit, w_any, w_accept;
    logic [ACC_W:0]    w_idle_sum, w_pacc_sum;

    assign w_ci      = (r_ph == P_WIN) ? r_j : r_ptr;
    assign w_ckey    = (r_ph == P_WIN) ? (r_wall[r_ptr] ? r_pid[r_ptr] : r_wpid[r_ptr])
                                       : r_key;
    assign w_ptr_nxt = (r_ptr == LAST) ? '0 : r_ptr + SW'(1);
    assign w_start   = !r_last_v ? '0 : ((r_last == LAST) ? '0 : r_last + SW'(1));
    assign w_tkill   = (r_tgt == '0) ? r_me : r_tgt;
    assign w_pnext   = (r_next_pid == '1) ? PID_W'(1) : r_next_pid + PID_W'(1);
    assign w_cpid    = r_pid[r_cur];
    assign w_hit     = r_wall[r_ptr] ? (w_cmp.live && !w_cmp.eq) : (w_cmp.live && w_cmp.eq);
    assign w_any     = r_acc | w_hit;
    assign w_accept  = i_in_valid && o_in_ready;
    assign w_idle_sum = {1'b0, r_idle} + {{(ACC_W-CFG_W+1){1'b0}}, r_tick};
    assign w_pacc_sum = {1'b0, r_pacc} + (ACC_W+1)'(1);

    rrps_cmp u_cmp (
        .i_state (r_state[w_ci]),
        .i_pid   (r_pid[w_ci]),
        .i_key   (w_ckey),
        .o_cmp   (w_cmp)
    );

    assign o_in_ready = (r_ph == P_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TASK_SLOTS; k++) begin
                r_state[k] <= ST_DEAD;
                r_pid[k]   <= '0;
                r_wpid[k]  <= '0;
                r_wall[k]  <= 1'b0;
                r_bterm[k] <= '0;
                r_ql[k]    <= {1'b0, QUANTUM_RESET};
            end
            r_qlen     <= QUANTUM_RESET;
            r_tick     <= TICK_RESET;
            r_ph       <= P_IDLE;
            r_cur_v    <= 1'b0;
            r_last_v   <= 1'b0;
            r_next_pid <= PID_W'(1);
            r_live     <= '0;
            r_idle     <= '0;
            r_pacc     <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_QUANTUM) r_qlen <= i_cfg_wdata;
                else r_tick <= i_cfg_wdata;
            end
            if (r_ov && i_out_ready && r_ph != P_DONE) r_ov <= 1'b0;

            case (r_ph)
                P_IDLE: begin
                    if (w_accept) begin
                        r_req     <= i_req_type;
                        r_tgt     <= i_target_pid;
                        r_dev     <= i_device_ready;
                        r_term    <= i_ready_terminal;
                        r_dir     <= i_io_direction;
                        r_has_cur <= r_cur_v;
                        r_me      <= r_cur_v ? r_pid[r_cur] : '0;
                        r_status  <= STAT_OK;
                        r_child   <= '0;
                        r_pre     <= 1'b0;
                        r_ph      <= P_EXEC;
                    end
                end
                P_EXEC: begin
                    r_ptr    <= '0;
                    r_found  <= 1'b0;
                    r_other1 <= 1'b0;
                    case (r_req)
                        REQ_RESET: r_ph <= P_CLR;
                        REQ_TICK: begin
                            r_ph <= P_WOUT;
                            if (!r_has_cur) begin
                                r_idle <= w_idle_sum[ACC_W] ? '1 : w_idle_sum[ACC_W-1:0];
                            end else if (r_ql[r_cur] <= {1'b0, r_tick}) begin
                                r_pre          <= 1'b1;
                                r_pacc         <= w_pacc_sum[ACC_W] ? '1
                                                                    : w_pacc_sum[ACC_W-1:0];
                                r_state[r_cur] <= ST_READY;
                                r_ql[r_cur]    <= {1'b0, r_qlen};
                                r_cur_v        <= 1'b0;
                            end else begin
                                r_ql[r_cur] <= r_ql[r_cur] - {1'b0, r_tick};
                            end
                        end
                        REQ_IORDY: r_ph <= P_SCAN;
                        REQ_READ, REQ_WRITE, REQ_CREATE, REQ_KILL, REQ_WAIT,
                        REQ_CPUERR: begin
                            if (!r_has_cur) begin
                                r_status <= STAT_NO_CUR;
                                r_ph     <= P_WOUT;
                            end else if (r_req == REQ_READ || r_req == REQ_WRITE) begin
                                r_ph <= P_WOUT;
                                if (!r_dev) begin
                                    r_state[r_cur] <= (r_req == REQ_READ) ? ST_BLK_RD
                                                                          : ST_BLK_WR;
                                    r_bterm[r_cur] <= TERM_W'(r_me - PID_W'(1));
                                    r_cur_v        <= 1'b0;
                                    r_status       <= STAT_BLOCKED;
                                end
                            end else if (r_req == REQ_CPUERR) begin
                                r_state[r_cur] <= ST_DEAD;
                                if (r_live != '0) r_live <= r_live - CW'(1);
                                r_cur_v <= 1'b0;
                                r_ph    <= P_WOUT;
                            end else if (r_req == REQ_WAIT
                                         && (r_tgt == '0 || r_tgt == r_me)) begin
                                r_status <= STAT_BAD_WAIT;
                                r_ph     <= P_WOUT;
                            end else begin
                                r_key <= (r_req == REQ_KILL) ? w_tkill : r_tgt;
                                r_ph  <= P_SCAN;
                            end
                        end
                        default: r_ph <= P_WOUT;
                    endcase
                end
                P_CLR: begin
                    r_state[r_ptr] <= ST_DEAD;
                    r_pid[r_ptr]   <= '0;
                    r_wpid[r_ptr]  <= '0;
                    r_wall[r_ptr]  <= 1'b0;
                    r_bterm[r_ptr] <= '0;
                    r_ql[r_ptr]    <= {1'b0, r_qlen};
                    r_ptr          <= w_ptr_nxt;
                    if (r_ptr == LAST) begin
                        r_state[0] <= ST_READY;
                        r_pid[0]   <= PID_W'(1);
                        r_cur_v    <= 1'b0;
                        r_last_v   <= 1'b0;
                        r_next_pid <= PID_W'(2);
                        r_live     <= CW'(1);
                        r_ph       <= P_WOUT;
                    end
                end
                P_SCAN: begin
                    case (r_req)
                        REQ_IORDY: begin
                            if (r_bterm[r_ptr] == r_term
                                && ((!r_dir && r_state[r_ptr] == ST_BLK_RD)
                                    || (r_dir && r_state[r_ptr] == ST_BLK_WR)))
                                r_state[r_ptr] <= ST_READY;
                        end
                        REQ_CREATE: begin
                            if (!r_found && !w_cmp.live) begin
                                r_found <= 1'b1;
                                r_fidx  <= r_ptr;
                            end
                        end
                        default: begin
                            if (!r_found && w_cmp.live && w_cmp.eq) begin
                                r_found <= 1'b1;
                                r_fidx  <= r_ptr;
                            end
                            if (w_cmp.live && !w_cmp.is_one) r_other1 <= 1'b1;
                        end
                    endcase
                    r_ptr <= w_ptr_nxt;
                    if (r_ptr == LAST) r_ph <= (r_req == REQ_IORDY) ? P_WOUT : P_ACT;
                end
                P_ACT: begin
                    r_ptr <= '0;
                    r_ph  <= P_WOUT;
                    case (r_req)
                        REQ_CREATE: begin
                            if (!r_found) begin
                                r_status <= STAT_NO_SLOT;
                            end else begin
                                r_state[r_fidx] <= ST_READY;
                                r_pid[r_fidx]   <= r_next_pid;
                                r_wpid[r_fidx]  <= '0;
                                r_wall[r_fidx]  <= 1'b0;
                                r_bterm[r_fidx] <= '0;
                                r_ql[r_fidx]    <= {1'b0, r_qlen};
                                r_child         <= r_next_pid;
                                r_next_pid      <= w_pnext;
                                r_live          <= r_live + CW'(1);
                            end
                        end
                        REQ_KILL: begin
                            if (r_me == PID_W'(1) && r_key == PID_W'(1) && r_other1) begin
                                r_state[r_cur] <= ST_BLK_WAIT;
                                r_wall[r_cur]  <= 1'b1;
                                r_wpid[r_cur]  <= '0;
                                r_cur_v        <= 1'b0;
                                r_status       <= STAT_BLOCKED;
                            end else if (!r_found) begin
                                r_status <= STAT_NOT_FND;
                            end else begin
                                r_state[r_fidx] <= ST_DEAD;
                                if (r_live != '0) r_live <= r_live - CW'(1);
                                if (r_cur_v && r_cur == r_fidx) r_cur_v <= 1'b0;
                            end
                        end
                        default: begin
                            if (r_found) begin
                                r_state[r_cur] <= ST_BLK_WAIT;
                                r_wpid[r_cur]  <= r_tgt;
                                r_wall[r_cur]  <= 1'b0;
                                r_cur_v        <= 1'b0;
                                r_status       <= STAT_BLOCKED;
                            end
                        end
                    endcase
                end
                P_WOUT: begin
                    r_j   <= '0;
                    r_acc <= 1'b0;
                    if (r_state[r_ptr] == ST_BLK_WAIT) begin
                        r_ph <= P_WIN;
                    end else begin
                        r_ptr <= w_ptr_nxt;
                        if (r_ptr == LAST) r_ph <= P_SPREP;
                    end
                end
                P_WIN: begin
                    r_acc <= w_any;
                    r_j   <= r_j + SW'(1);
                    if (r_j == LAST) begin
                        if (!w_any) begin
                            r_state[r_ptr] <= ST_READY;
                            r_wall[r_ptr]  <= 1'b0;
                            r_wpid[r_ptr]  <= '0;
                        end
                        r_ptr <= w_ptr_nxt;
                        r_ph  <= (r_ptr == LAST) ? P_SPREP : P_WOUT;
                    end
                end
                P_SPREP: begin
                    if (r_cur_v && r_state[r_cur] == ST_RUN) r_state[r_cur] <= ST_READY;
                    r_cur_v <= 1'b0;
                    r_ptr   <= w_start;
                    r_cnt   <= '0;
                    r_ph    <= P_SCHED;
                end
                P_SCHED: begin
                    if (r_state[r_ptr] == ST_READY) begin
                        r_state[r_ptr] <= ST_RUN;
                        r_cur          <= r_ptr;
                        r_cur_v        <= 1'b1;
                        r_last         <= r_ptr;
                        r_last_v       <= 1'b1;
                        if (r_ql[r_ptr] == '0) r_ql[r_ptr] <= {1'b0, r_qlen};
                        r_ph <= P_DONE;
                    end else begin
                        r_ptr <= w_ptr_nxt;
                        r_cnt <= r_cnt + CW'(1);
                        if (r_cnt == CW'(TASK_SLOTS - 1)) r_ph <= P_DONE;
                    end
                end
                P_DONE: begin
                    if (!r_ov || i_out_ready) begin
                        r_ov     <= 1'b1;
                        r_orv    <= r_cur_v;
                        r_oslot  <= r_cur_v ? r_cur : '0;
                        r_opid   <= r_cur_v ? w_cpid : '0;
                        r_oterm  <= r_cur_v ? TERM_W'(w_cpid - PID_W'(1)) : '0;
                        r_ostat  <= r_status;
                        r_ochild <= r_child;
                        r_opre   <= r_pre;
                        r_odone  <= (r_live == '0);
                        r_ph     <= P_IDLE;
                    end
                end
                default: r_ph <= P_IDLE;
            endcase
        end
    end

    assign o_out_valid        = r_ov;
    assign o_running_valid    = r_orv;
    assign o_running_slot     = r_oslot;
    assign o_running_pid      = r_opid;
    assign o_running_terminal = r_oterm;
    assign o_status           = r_ostat;
    assign o_child_pid        = r_ochild;
    assign o_preempted        = r_opre;
    assign o_all_done         = r_odone;
    assign o_idle_time        = r_idle_q;
    assign o_preempt_total    = r_pacc_q;

    always_ff @(posedge i_clk) begin
        if (r_ph == P_DONE && (!r_ov || i_out_ready)) begin
            r_idle_q <= r_idle;
            r_pacc_q <= r_pacc;
        end
    end

endmodule
